FILE: sv/matrix_chain_order_dp_defines.svh
// Assertion macros for the matrix-chain order block.
// Used by the top level only; no other dependencies.
`ifndef MATRIX_CHAIN_ORDER_DP_DEFINES_SVH
`define MATRIX_CHAIN_ORDER_DP_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked at every edge outside reset.
`define MCO_ASSERT(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("mco invariant violated");
// Same-cycle implication checked at every edge outside reset.
`define MCO_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mco implication violated");
`else
`define MCO_ASSERT(name, clk, rst, expr)
`define MCO_ASSERT_IMP(name, clk, rst, ante, cons)
`endif

`endif

FILE: sv/mco_pkg.sv
// Shared types and constants for the matrix-chain order block.
// No dependencies.
package mco_pkg;

   localparam int IDX_W  = 4;
   localparam int SPL_W  = 3;
   localparam int COST_W = 34;
   localparam int ST_W   = 2;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_PAIR_A,
      S_PAIR_B,
      S_PAIR_C,
      S_K_RD,
      S_K_MUL,
      S_K_ACC,
      S_EMIT
   } state_type;

   // Strobes from the sequencer to the cost unit.
   typedef struct packed {
      logic latch_di;
      logic form_pij;
      logic mul;
      logic zero_left;
      logic zero_right;
      logic acc;
      logic first;
   } cu_ctrl_type;

endpackage

FILE: sv/mco_ram_1w1r.sv
// Synchronous RAM, one write port and one registered read port.
// No dependencies; holds the dimension list.
module mco_ram_1w1r #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 9,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] store [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
      rdata_ff <= store[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/mco_ram_1w2r.sv
// Synchronous RAM, one write port and two registered read ports.
// No dependencies; holds the subchain cost table.
module mco_ram_1w2r #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr0,
   input  logic [AW-1:0]    raddr1,
   output logic [WIDTH-1:0] rdata0,
   output logic [WIDTH-1:0] rdata1
);

   logic [WIDTH-1:0] store [DEPTH];
   logic [WIDTH-1:0] rdata0_ff;
   logic [WIDTH-1:0] rdata1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
      rdata0_ff <= store[raddr0];
      rdata1_ff <= store[raddr1];
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

FILE: sv/mco_cost_unit.sv
// Split-cost arithmetic: dimension products, partial sum, saturation, best-split tracking.
// Depends on mco_pkg.
module mco_cost_unit #(
   parameter int MAX_MATRICES = 8,
   parameter int DIM_BITS = 10,
   localparam int IW = $clog2(MAX_MATRICES + 1)
) (
   input  logic                          clock,
   input  mco_pkg::cu_ctrl_type          ctl,
   input  logic [DIM_BITS-1:0]           rd_dim,
   input  logic [mco_pkg::COST_W-1:0]    cost_left,
   input  logic [mco_pkg::COST_W-1:0]    cost_right,
   input  logic [IW-1:0]                 k,
   output logic [mco_pkg::COST_W-1:0]    best_cost,
   output logic [IW-1:0]                 best_k
);

   localparam int PW = 3 * DIM_BITS;
   localparam int SW = mco_pkg::COST_W + 1;
   localparam int TW = ((PW > SW) ? PW : SW) + 1;

   logic [DIM_BITS-1:0]          di_ff;
   logic [2*DIM_BITS-1:0]        pij_ff;
   logic [SW-1:0]                sum_ff;
   logic [PW-1:0]                prod_ff;
   logic [mco_pkg::COST_W-1:0]   best_ff;
   logic [IW-1:0]                bk_ff;

   logic [mco_pkg::COST_W-1:0]   left;
   logic [mco_pkg::COST_W-1:0]   right;
   logic [TW-1:0]                total;
   logic [mco_pkg::COST_W-1:0]   q;

   assign left  = ctl.zero_left  ? '0 : cost_left;
   assign right = ctl.zero_right ? '0 : cost_right;
   assign total = TW'(sum_ff) + TW'(prod_ff);
   assign q     = (total > TW'(mco_pkg::COST_MAX)) ? mco_pkg::COST_MAX
                                                   : total[mco_pkg::COST_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.latch_di) begin
         di_ff <= rd_dim;
      end
      if (ctl.form_pij) begin
         pij_ff <= di_ff * rd_dim;
      end
      if (ctl.mul) begin
         sum_ff  <= SW'(left) + SW'(right);
         prod_ff <= pij_ff * rd_dim;
      end
      // strict compare keeps the smallest k on ties
      if (ctl.acc && (ctl.first || (q < best_ff))) begin
         best_ff <= q;
         bk_ff   <= k;
      end
   end

   assign best_cost = best_ff;
   assign best_k    = bk_ff;

endmodule

FILE: sv/matrix_chain_order_dp.sv
// Matrix-chain order solver. Dimensions load one beat per cycle while idle; the
// beat with req_last closes the list and starts the table fill, during which
// req_stall is high. Each subchain (i,j) reads p[i-1] and p[j] and forms their
// product, then for each split k reads both cost-table ports and p[k],
// multiplies, and adds and compares, then emits its beat. A single matrix or too
// short a list goes from the start state straight to its emit. Each emit waits
// while rsp_stall holds the previous beat. Results come out in order of chain
// length then i, one beat per subchain of two or more matrices, the last one
// flagged by rsp_final_res.
// Depends on mco_pkg, the RAM and cost-unit modules, and the defines header.
`include "matrix_chain_order_dp_defines.svh"

module matrix_chain_order_dp #(
   parameter int MAX_MATRICES = 8,
   parameter int DIM_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [DIM_BITS-1:0]           req_dimension,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mco_pkg::IDX_W-1:0]     rsp_first_matrix,
   output logic [mco_pkg::IDX_W-1:0]     rsp_last_matrix,
   output logic [mco_pkg::COST_W-1:0]    rsp_min_cost,
   output logic [mco_pkg::SPL_W-1:0]     rsp_split_point,
   output logic [mco_pkg::ST_W-1:0]      rsp_status,
   output logic                          rsp_final_res
);

   localparam int NDIMS = MAX_MATRICES + 1;
   localparam int IW = $clog2(NDIMS);
   localparam int CW = $clog2(NDIMS + 1);

   mco_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] len_ff, len_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] k_ff, k_in;
   logic          special_ff, special_in;
   logic [mco_pkg::ST_W-1:0] st_ff, st_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mco_pkg::IDX_W-1:0]   rsp_first_ff, rsp_first_in;
   logic [mco_pkg::IDX_W-1:0]   rsp_lastm_ff, rsp_lastm_in;
   logic [mco_pkg::COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic [mco_pkg::SPL_W-1:0]   rsp_split_ff, rsp_split_in;
   logic [mco_pkg::ST_W-1:0]    rsp_st_ff, rsp_st_in;
   logic                        rsp_fin_ff, rsp_fin_in;

   logic                        dim_we;
   logic [IW-1:0]               dim_ra;
   logic [DIM_BITS-1:0]         dim_rd;
   logic                        cost_we;
   logic [2*IW-1:0]             cost_ra0, cost_ra1, cost_wa;
   logic [mco_pkg::COST_W-1:0]  cost_rd0, cost_rd1;
   logic [mco_pkg::COST_W-1:0]  best_cost;
   logic [IW-1:0]               best_k;
   mco_pkg::cu_ctrl_type        ctl;

   logic          req_acc;
   logic          out_free;
   logic [CW-1:0] count_m1;
   logic [IW-1:0] k_p1;
   logic          last_len;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign count_m1 = count_ff - CW'(1);
   assign k_p1     = k_ff + IW'(1);
   assign last_len = (len_ff == n_ff);
   assign req_stall = (state_ff != mco_pkg::S_IDLE);
   assign dim_we   = req_acc && (count_ff < CW'(NDIMS));
   assign cost_wa  = {i_ff, j_ff};
   assign cost_ra0 = {i_ff, k_ff};
   assign cost_ra1 = {k_p1, j_ff};

   mco_ram_1w1r #(
      .WIDTH (DIM_BITS),
      .DEPTH (NDIMS)
   ) u_dims (
      .clock (clock),
      .we    (dim_we),
      .waddr (count_ff[IW-1:0]),
      .wdata (req_dimension),
      .raddr (dim_ra),
      .rdata (dim_rd)
   );

   mco_ram_1w2r #(
      .WIDTH (mco_pkg::COST_W),
      .DEPTH (2 ** (2 * IW))
   ) u_cost (
      .clock  (clock),
      .we     (cost_we),
      .waddr  (cost_wa),
      .wdata  (best_cost),
      .raddr0 (cost_ra0),
      .raddr1 (cost_ra1),
      .rdata0 (cost_rd0),
      .rdata1 (cost_rd1)
   );

   mco_cost_unit #(
      .MAX_MATRICES (MAX_MATRICES),
      .DIM_BITS     (DIM_BITS)
   ) u_cu (
      .clock      (clock),
      .ctl        (ctl),
      .rd_dim     (dim_rd),
      .cost_left  (cost_rd0),
      .cost_right (cost_rd1),
      .k          (k_ff),
      .best_cost  (best_cost),
      .best_k     (best_k)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      n_in       = n_ff;
      len_in     = len_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      special_in = special_ff;
      st_in      = st_ff;
      dim_ra     = k_ff;
      cost_we    = 1'b0;
      ctl        = '0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_first_in = rsp_first_ff;
      rsp_lastm_in = rsp_lastm_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_split_in = rsp_split_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_fin_in   = rsp_fin_ff;

      unique case (state_ff)
         mco_pkg::S_IDLE: begin
            if (req_acc) begin
               if (count_ff < CW'(NDIMS)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  state_in = mco_pkg::S_START;
               end
            end
         end
         mco_pkg::S_START: begin
            n_in   = count_m1[IW-1:0];
            st_in  = dropped_ff ? mco_pkg::ST_DROPPED : mco_pkg::ST_OK;
            len_in = IW'(2);
            i_in   = IW'(1);
            j_in   = IW'(2);
            special_in = 1'b0;
            state_in   = mco_pkg::S_PAIR_A;
            if (count_ff < CW'(2)) begin
               i_in  = '0;
               j_in  = '0;
               st_in = mco_pkg::ST_SHORT;
               special_in = 1'b1;
               state_in   = mco_pkg::S_EMIT;
            end else if (count_ff == CW'(2)) begin
               j_in = IW'(1);
               special_in = 1'b1;
               state_in   = mco_pkg::S_EMIT;
            end
         end
         mco_pkg::S_PAIR_A: begin
            dim_ra   = i_ff - IW'(1);
            state_in = mco_pkg::S_PAIR_B;
         end
         mco_pkg::S_PAIR_B: begin
            dim_ra       = j_ff;
            ctl.latch_di = 1'b1;
            state_in     = mco_pkg::S_PAIR_C;
         end
         mco_pkg::S_PAIR_C: begin
            ctl.form_pij = 1'b1;
            k_in         = i_ff;
            state_in     = mco_pkg::S_K_RD;
         end
         mco_pkg::S_K_RD: begin
            state_in = mco_pkg::S_K_MUL;
         end
         mco_pkg::S_K_MUL: begin
            ctl.mul        = 1'b1;
            ctl.zero_left  = (k_ff == i_ff);
            ctl.zero_right = (k_p1 == j_ff);
            state_in       = mco_pkg::S_K_ACC;
         end
         mco_pkg::S_K_ACC: begin
            ctl.acc   = 1'b1;
            ctl.first = (k_ff == i_ff);
            if (k_p1 == j_ff) begin
               state_in = mco_pkg::S_EMIT;
            end else begin
               k_in     = k_p1;
               state_in = mco_pkg::S_K_RD;
            end
         end
         mco_pkg::S_EMIT: begin
            // hold until the output register can take the beat
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_first_in = mco_pkg::IDX_W'(i_ff);
               rsp_lastm_in = mco_pkg::IDX_W'(j_ff);
               rsp_cost_in  = special_ff ? '0 : best_cost;
               rsp_split_in = special_ff ? '0 : mco_pkg::SPL_W'(best_k);
               rsp_st_in    = st_ff;
               rsp_fin_in   = special_ff || last_len;
               cost_we      = !special_ff;
               if (special_ff || last_len) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = mco_pkg::S_IDLE;
               end else if (j_ff == n_ff) begin
                  len_in   = len_ff + IW'(1);
                  i_in     = IW'(1);
                  j_in     = len_ff + IW'(1);
                  state_in = mco_pkg::S_PAIR_A;
               end else begin
                  i_in     = i_ff + IW'(1);
                  j_in     = j_ff + IW'(1);
                  state_in = mco_pkg::S_PAIR_A;
               end
            end
         end
         default: begin
            state_in = mco_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mco_pkg::S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      len_ff       <= len_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      special_ff   <= special_in;
      st_ff        <= st_in;
      rsp_first_ff <= rsp_first_in;
      rsp_lastm_ff <= rsp_lastm_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_split_ff <= rsp_split_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_matrix = rsp_first_ff;
   assign rsp_last_matrix  = rsp_lastm_ff;
   assign rsp_min_cost     = rsp_cost_ff;
   assign rsp_split_point  = rsp_split_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_final_res    = rsp_fin_ff;

   `MCO_ASSERT_IMP(a_k_in_range, clock, reset,
      (state_ff == mco_pkg::S_K_MUL || state_ff == mco_pkg::S_K_ACC),
      (i_ff <= k_ff && k_ff < j_ff && j_ff <= n_ff))
   `MCO_ASSERT_IMP(a_cost_write_pair, clock, reset, cost_we,
      (state_ff == mco_pkg::S_EMIT && i_ff < j_ff && j_ff <= n_ff))
   `MCO_ASSERT(a_count_bound, clock, reset, (count_ff <= CW'(NDIMS)))

endmodule

FILE: test/tb.sv
// Self-checking testbench for matrix_chain_order_dp: directed chains, then random chains.
// Depends on mco_pkg and the matrix_chain_order_dp RTL; reads nothing else.
`timescale 1ns / 100ps

module tb;

   localparam int DIM_W     = 10;
   localparam int MAX_MAT   = 8;
   localparam int NDIMS     = MAX_MAT + 1;
   localparam int N_DIRECT  = 23;
   localparam int N_ITEMS   = 420;
   localparam int CYC_LIMIT = 400000;
   localparam int HOLD_CYC  = 500;
   localparam int DRAIN_CYC = 64;

   typedef struct packed {
      logic [mco_pkg::IDX_W-1:0]  first_m;
      logic [mco_pkg::IDX_W-1:0]  last_m;
      logic [mco_pkg::COST_W-1:0] cost;
      logic [mco_pkg::SPL_W-1:0]  split;
      mco_pkg::status_type        status;
      logic                       fin;
   } chain_res_type;

   typedef struct packed {
      logic [DIM_W-1:0] dim;
      logic             last;
      logic             typed;
      chain_res_type    want;
   } dim_row_type;

   localparam chain_res_type NO_RES = '{4'd0, 4'd0, 34'd0, 3'd0, mco_pkg::ST_OK, 1'b0};

   // Rows with a typed result carry exactly one expected beat; the rest use the predictor.
   localparam dim_row_type DIRECT_TAB [N_DIRECT] = '{
      '{10'd1,    1'b1, 1'b1, '{4'd0, 4'd0, 34'd0, 3'd0, mco_pkg::ST_SHORT, 1'b1}},
      '{10'd1023, 1'b0, 1'b0, NO_RES},
      '{10'd1023, 1'b1, 1'b1, '{4'd1, 4'd1, 34'd0, 3'd0, mco_pkg::ST_OK, 1'b1}},
      '{10'd1023, 1'b0, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 1'b0, NO_RES},
      '{10'd1023, 1'b1, 1'b1, '{4'd1, 4'd2, 34'd1070599167, 3'd1, mco_pkg::ST_OK, 1'b1}},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b1, 1'b1, '{4'd1, 4'd2, 34'd1, 3'd1, mco_pkg::ST_OK, 1'b1}},
      '{10'd10,   1'b0, 1'b0, NO_RES},
      '{10'd30,   1'b0, 1'b0, NO_RES},
      '{10'd5,    1'b0, 1'b0, NO_RES},
      '{10'd60,   1'b1, 1'b0, NO_RES},
      // ten equal dimensions: the tenth is dropped and every split ties
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b0, 1'b0, NO_RES},
      '{10'd1,    1'b1, 1'b0, NO_RES}
   };

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [DIM_W-1:0]             req_dimension;
   logic                         req_last;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [mco_pkg::IDX_W-1:0]    rsp_first_matrix;
   logic [mco_pkg::IDX_W-1:0]    rsp_last_matrix;
   logic [mco_pkg::COST_W-1:0]   rsp_min_cost;
   logic [mco_pkg::SPL_W-1:0]    rsp_split_point;
   logic [mco_pkg::ST_W-1:0]     rsp_status;
   logic                         rsp_final_res;

   // predictor state
   logic [DIM_W-1:0]           chain_dims [0:NDIMS-1];
   int                         dims_held;
   bit                         dims_dropped;
   logic [mco_pkg::COST_W-1:0] cost_tab [1:MAX_MAT][1:MAX_MAT];

   chain_res_type pending_results [$];
   int            fail_count;
   int unsigned   cycle_count;
   bit            idle_on;
   bit            long_hold;

   matrix_chain_order_dp dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_dimension    (req_dimension),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_first_matrix (rsp_first_matrix),
      .rsp_last_matrix  (rsp_last_matrix),
      .rsp_min_cost     (rsp_min_cost),
      .rsp_split_point  (rsp_split_point),
      .rsp_status       (rsp_status),
      .rsp_final_res    (rsp_final_res)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Take one dimension; on the closing one fill the tables and list every expected result beat.
   function automatic void solve_chain_beat(input logic [DIM_W-1:0] d, input logic l,
                                            output chain_res_type res_list [$]);
      mco_pkg::status_type st;
      chain_res_type r;
      int         n;
      int         j;
      bit [63:0]  best;
      bit [63:0]  q;
      logic [mco_pkg::SPL_W-1:0] bk;
      res_list = {};
      if (dims_held < NDIMS) begin
         chain_dims[dims_held] = d;
         dims_held++;
      end else begin
         dims_dropped = 1'b1;
      end
      if (!l) return;
      st = dims_dropped ? mco_pkg::ST_DROPPED : mco_pkg::ST_OK;
      if (dims_held < 2) begin
         r = NO_RES;
         r.status = mco_pkg::ST_SHORT;
         r.fin = 1'b1;
         res_list.push_back(r);
         dims_held = 0;
         dims_dropped = 1'b0;
         return;
      end
      n = dims_held - 1;
      for (int i = 1; i <= n; i++) cost_tab[i][i] = '0;
      if (n == 1) begin
         r = NO_RES;
         r.first_m = 4'd1;
         r.last_m = 4'd1;
         r.status = st;
         r.fin = 1'b1;
         res_list.push_back(r);
      end
      for (int len = 2; len <= n; len++) begin
         for (int i = 1; i + len - 1 <= n; i++) begin
            j = i + len - 1;
            best = '1;
            bk = '0;
            for (int k = i; k < j; k++) begin
               q = 64'(cost_tab[i][k]) + 64'(cost_tab[k+1][j])
                 + 64'(chain_dims[i-1]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
               if (q > 64'(mco_pkg::COST_MAX)) q = 64'(mco_pkg::COST_MAX);
               // strict compare: the smallest k wins a tie
               if (q < best) begin
                  best = q;
                  bk = mco_pkg::SPL_W'(k);
               end
            end
            cost_tab[i][j] = best[mco_pkg::COST_W-1:0];
            r.first_m = mco_pkg::IDX_W'(i);
            r.last_m = mco_pkg::IDX_W'(j);
            r.cost = best[mco_pkg::COST_W-1:0];
            r.split = bk;
            r.status = st;
            r.fin = (len == n);
            res_list.push_back(r);
         end
      end
      dims_held = 0;
      dims_dropped = 1'b0;
   endfunction

   // Offer one dimension beat, hold it until accepted, then book its results.
   task automatic send_dim(input logic [DIM_W-1:0] d, input logic l,
                           input logic typed, input chain_res_type want);
      chain_res_type got [$];
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dimension <= d;
      req_last <= l;
      do @(posedge clock); while (req_stall);
      solve_chain_beat(d, l, got);
      if (typed) pending_results.push_back(want);
      else foreach (got[m]) pending_results.push_back(got[m]);
   endtask

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYC) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      chain_res_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected beat: (%0d,%0d) cost %0d split %0d st %0d fin %0d",
                        rsp_first_matrix, rsp_last_matrix, rsp_min_cost,
                        rsp_split_point, rsp_status, rsp_final_res);
         end else begin
            e = pending_results.pop_front();
            if (rsp_first_matrix !== e.first_m || rsp_last_matrix !== e.last_m ||
                rsp_min_cost !== e.cost || rsp_split_point !== e.split ||
                rsp_status !== e.status || rsp_final_res !== e.fin) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch exp (%0d,%0d) cost %0d split %0d st %0d fin %0d",
                           e.first_m, e.last_m, e.cost, e.split, e.status, e.fin);
                  $display("         got (%0d,%0d) cost %0d split %0d st %0d fin %0d",
                           rsp_first_matrix, rsp_last_matrix, rsp_min_cost,
                           rsp_split_point, rsp_status, rsp_final_res);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYC_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      int sent;
      int run_len;
      bit hold_done;
      logic [DIM_W-1:0] d;
      reset = 1'b1;
      req_valid = 1'b0;
      req_dimension = '0;
      req_last = 1'b0;
      dims_held = 0;
      dims_dropped = 1'b0;
      fail_count = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      long_hold = 1'b0;
      hold_done = 1'b0;
      sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECT; r++) begin
         send_dim(DIRECT_TAB[r].dim, DIRECT_TAB[r].last, DIRECT_TAB[r].typed,
                  DIRECT_TAB[r].want);
         sent++;
      end

      // mostly well-formed chains; a few too short or too long
      while (sent < N_ITEMS) begin
         if (sent >= N_ITEMS - 60) idle_on = 1'b0;
         if (!hold_done && sent >= 150) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         case ($urandom_range(0, 19))
            0:       run_len = 1;
            1:       run_len = $urandom_range(10, 12);
            2, 3, 4: run_len = NDIMS;
            default: run_len = $urandom_range(2, NDIMS);
         endcase
         for (int m = 0; m < run_len; m++) begin
            case ($urandom_range(0, 3))
               0:       d = DIM_W'($urandom_range(1, 16));
               1:       d = $urandom_range(0, 1) ? 10'd1023 : 10'd512;
               default: d = DIM_W'($urandom_range(1, 1023));
            endcase
            send_dim(d, m == run_len - 1, 1'b0, NO_RES);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: matrix_chain_order_dp.f
+incdir+sv
sv/mco_pkg.sv
sv/mco_ram_1w1r.sv
sv/mco_ram_1w2r.sv
sv/mco_cost_unit.sv
sv/matrix_chain_order_dp.sv
test/tb.sv
